[rtl/core/mmp_pkg.sv]
// Shared constants and types for the Michaelis-Menten propensity core.
package mmp_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned KM_W       = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KM   = 8'd0,
    CFG_KCAT = 8'd1
  } cfg_reg_e;

endpackage

[rtl/core/mmp_mul.sv]
// Three-stage multiply-add built from four registered partial products.
module mmp_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 32,
  parameter int unsigned OW = 64,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [OW-1:0] c_i,
  input  logic [SW-1:0] side_i,
  output logic          vld_o,
  output logic [OW-1:0] p_o,
  output logic [SW-1:0] side_o
);

  localparam int unsigned AL  = (AW + 1) / 2;
  localparam int unsigned AHW = AW - AL;
  localparam int unsigned BL  = (BW + 1) / 2;
  localparam int unsigned BHW = BW - BL;

  logic [AL+BL-1:0]   ll_q;
  logic [AL+BHW-1:0]  lh_q;
  logic [AHW+BL-1:0]  hl_q;
  logic [AHW+BHW-1:0] hh_q;
  logic [OW-1:0]      c1_q, x_q, y_q, x_d, y_d, p_q;
  logic [SW-1:0]      side1_q, side2_q, side3_q;
  logic               vld1_q, vld2_q, vld3_q;

  always_comb begin
    x_d = OW'(ll_q) + (OW'(lh_q) << BL) + c1_q;
    y_d = (OW'(hl_q) << AL) + (OW'(hh_q) << (AL + BL));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q    <= a_i[AL-1:0] * b_i[BL-1:0];
      lh_q    <= a_i[AL-1:0] * b_i[BW-1:BL];
      hl_q    <= a_i[AW-1:AL] * b_i[BL-1:0];
      hh_q    <= a_i[AW-1:AL] * b_i[BW-1:BL];
      c1_q    <= c_i;
      side1_q <= side_i;
      x_q     <= x_d;
      y_q     <= y_d;
      side2_q <= side1_q;
      p_q     <= x_q + y_q;
      side3_q <= side2_q;
    end
  end

  assign vld_o  = vld3_q;
  assign p_o    = p_q;
  assign side_o = side3_q;

endmodule

[rtl/core/mmp_sqrt.sv]
// Pipelined integer square root, one root bit per register stage.
module mmp_sqrt #(
  parameter int unsigned RAD_W  = 75,
  parameter int unsigned ROOT_W = 38,
  parameter int unsigned SW     = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SW-1:0]     side_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SW-1:0]     side_o
);

  localparam int unsigned DW = 2 * ROOT_W + 1;

  logic              vld_q  [ROOT_W+1];
  logic [ROOT_W-1:0] r_q    [ROOT_W+1];
  logic [DW-1:0]     rem_q  [ROOT_W+1];
  logic [SW-1:0]     side_q [ROOT_W+1];

  assign vld_q[0]  = vld_i;
  assign r_q[0]    = '0;
  assign rem_q[0]  = DW'(rad_i);
  assign side_q[0] = side_i;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [DW-1:0]     delta;
    logic              take;
    logic [ROOT_W-1:0] r_d;
    logic [DW-1:0]     rem_d;

    always_comb begin
      delta = (DW'(r_q[k]) << (B + 1)) | (DW'(1) << (2 * B));
      take  = delta <= rem_q[k];
      r_d   = take ? (r_q[k] | (ROOT_W'(1) << B)) : r_q[k];
      rem_d = take ? (rem_q[k] - delta) : rem_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]    <= r_d;
        rem_q[k+1]  <= rem_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W];
  assign root_o = r_q[ROOT_W];
  assign side_o = side_q[ROOT_W];

endmodule

[rtl/core/mmp_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
module mmp_div #(
  parameter int unsigned NW  = 88,
  parameter int unsigned DNW = 37,
  parameter int unsigned QW  = 56,
  parameter int unsigned SW  = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           vld_i,
  input  logic [NW-1:0]  num_i,
  input  logic [DNW-1:0] den_i,
  input  logic [SW-1:0]  side_i,
  output logic           vld_o,
  output logic [QW-1:0]  quo_o,
  output logic [SW-1:0]  side_o
);

  logic           vld_q  [QW+1];
  logic [DNW-1:0] rem_q  [QW+1];
  logic [QW-1:0]  low_q  [QW+1];
  logic [QW-1:0]  quo_q  [QW+1];
  logic [DNW-1:0] den_q  [QW+1];
  logic [SW-1:0]  side_q [QW+1];

  assign vld_q[0]  = vld_i;
  assign rem_q[0]  = DNW'(num_i >> QW);
  assign low_q[0]  = num_i[QW-1:0];
  assign quo_q[0]  = '0;
  assign den_q[0]  = den_i;
  assign side_q[0] = side_i;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DNW:0]   trial;
    logic           ge;
    logic [DNW-1:0] rem_d;

    always_comb begin
      trial = {rem_q[k], low_q[k][QW-1]};
      ge    = trial >= {1'b0, den_q[k]};
      rem_d = ge ? DNW'(trial - {1'b0, den_q[k]}) : DNW'(trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= rem_d;
        low_q[k+1]  <= low_q[k] << 1;
        quo_q[k+1]  <= (quo_q[k] << 1) | QW'(ge);
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign vld_o  = vld_q[QW];
  assign quo_o  = quo_q[QW];
  assign side_o = side_q[QW];

endmodule

[rtl/core/michaelis_menten_propensity_core.sv]
// Top level of the total quasi-steady-state Michaelis-Menten propensity pipeline.
//
//   Channel  Handshake                Payload
//   cfg      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//   in       in_valid_i/in_stall_o    substrate_count_i, enzyme_count_i
//   out      out_valid_o/out_stall_i  free_substrate_o, propensity_o
//
// One item enters per cycle unless a valid result is held by out_stall_i; most of the
// pipeline depth lies in the bit-per-stage square root and divider stages.
// Reset clears all valid bits and loads Km and kcat with 1.0.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
module michaelis_menten_propensity_core
  import mmp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 20,
  parameter int unsigned FRAC_BITS   = 16,
  localparam int unsigned SF_W   = COUNT_WIDTH + FRAC_BITS,
  localparam int unsigned PROP_W = (2 * COUNT_WIDTH + FRAC_BITS > 64) ? 64
                                   : 2 * COUNT_WIDTH + FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [COUNT_WIDTH-1:0] substrate_count_i,
  input  logic [COUNT_WIDTH-1:0] enzyme_count_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SF_W-1:0]        free_substrate_o,
  output logic [PROP_W-1:0]      propensity_o
);

  localparam int unsigned SFIX_W = COUNT_WIDTH + FRAC_BITS;
  localparam int unsigned MAG_W  = (SFIX_W > KM_W ? SFIX_W : KM_W) + 1;
  localparam int unsigned KM4_W  = KM_W + 2;
  localparam int unsigned PA_W   = KM4_W + SFIX_W;
  localparam int unsigned RAD_W  = 2 * MAG_W + 1;
  localparam int unsigned ROOT_W = MAG_W + 1;
  localparam int unsigned SUM_W  = ROOT_W + 1;
  localparam int unsigned DEN_W  = (SF_W > KM_W ? SF_W : KM_W) + 1;
  localparam int unsigned KCE_W  = KM_W + COUNT_WIDTH;
  localparam int unsigned NUM_W  = KCE_W + SF_W;
  localparam int unsigned HI_W   = NUM_W - PROP_W;
  localparam int unsigned SA_W   = MAG_W + 1 + KCE_W + KM_W;
  localparam int unsigned SD_W   = SF_W + KM_W;
  localparam int unsigned SQ_W   = SF_W + 2;

  logic            pipe_en;
  logic [KM_W-1:0] km_q, kc_q;

  assign pipe_en     = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !pipe_en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      km_q <= KM_W'(1) << FRAC_BITS;
      kc_q <= KM_W'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_KM:   km_q <= cfg_data_i;
        CFG_KCAT: kc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input stage: signed difference S - Km - E as magnitude and sign, plus kcat * E.
  logic [SFIX_W-1:0] sfix_d;
  logic [MAG_W-1:0]  sub_d, mag_d;
  logic              neg_d;

  always_comb begin
    sfix_d = SFIX_W'(substrate_count_i) << FRAC_BITS;
    sub_d  = MAG_W'(km_q) + (MAG_W'(enzyme_count_i) << FRAC_BITS);
    neg_d  = MAG_W'(sfix_d) < sub_d;
    mag_d  = neg_d ? sub_d - MAG_W'(sfix_d) : MAG_W'(sfix_d) - sub_d;
  end

  logic              st1_vld_q;
  logic [MAG_W-1:0]  st1_mag_q;
  logic              st1_neg_q;
  logic [SFIX_W-1:0] st1_sfix_q;
  logic [KCE_W-1:0]  st1_kce_q;
  logic [KM_W-1:0]   st1_km_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st1_vld_q <= 1'b0;
    end else if (pipe_en) begin
      st1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st1_mag_q  <= mag_d;
      st1_neg_q  <= neg_d;
      st1_sfix_q <= sfix_d;
      st1_kce_q  <= kc_q * enzyme_count_i;
      st1_km_q   <= km_q;
    end
  end

  // Radicand: 4 * Km * S, then d * d added to it.
  logic             ma_vld;
  logic [PA_W-1:0]  ma_p;
  logic [SA_W-1:0]  ma_side;

  mmp_mul #(.AW(KM4_W), .BW(SFIX_W), .OW(PA_W), .SW(SA_W)) u_mul_kms (
    .clk_i, .rst_ni, .en_i(pipe_en), .vld_i(st1_vld_q),
    .a_i({st1_km_q, 2'b00}), .b_i(st1_sfix_q), .c_i('0),
    .side_i({st1_mag_q, st1_neg_q, st1_kce_q, st1_km_q}),
    .vld_o(ma_vld), .p_o(ma_p), .side_o(ma_side)
  );

  logic             mb_vld;
  logic [RAD_W-1:0] mb_p;
  logic [SA_W-1:0]  mb_side;

  mmp_mul #(.AW(MAG_W), .BW(MAG_W), .OW(RAD_W), .SW(SA_W)) u_mul_sq (
    .clk_i, .rst_ni, .en_i(pipe_en), .vld_i(ma_vld),
    .a_i(ma_side[SA_W-1 -: MAG_W]), .b_i(ma_side[SA_W-1 -: MAG_W]),
    .c_i(RAD_W'(ma_p)), .side_i(ma_side),
    .vld_o(mb_vld), .p_o(mb_p), .side_o(mb_side)
  );

  logic              sq_vld;
  logic [ROOT_W-1:0] sq_root;
  logic [SA_W-1:0]   sq_side;

  mmp_sqrt #(.RAD_W(RAD_W), .ROOT_W(ROOT_W), .SW(SA_W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(pipe_en), .vld_i(mb_vld), .rad_i(mb_p), .side_i(mb_side),
    .vld_o(sq_vld), .root_o(sq_root), .side_o(sq_side)
  );

  // Free substrate: half of (d + root), saturated to its field.
  logic [MAG_W-1:0]  sq_mag;
  logic              sq_neg;
  logic [KCE_W-1:0]  sq_kce;
  logic [KM_W-1:0]   sq_km;
  logic [SUM_W-1:0]  sum_d;
  logic [ROOT_W-1:0] half_d;
  logic [SF_W-1:0]   sfree_d;

  assign {sq_mag, sq_neg, sq_kce, sq_km} = sq_side;

  always_comb begin
    sum_d   = sq_neg ? SUM_W'(sq_root) - SUM_W'(sq_mag) : SUM_W'(sq_root) + SUM_W'(sq_mag);
    half_d  = sum_d[SUM_W-1:1];
    sfree_d = (half_d > ROOT_W'({SF_W{1'b1}})) ? {SF_W{1'b1}} : half_d[SF_W-1:0];
  end

  logic             st2_vld_q;
  logic [SF_W-1:0]  st2_sfree_q;
  logic [KCE_W-1:0] st2_kce_q;
  logic [KM_W-1:0]  st2_km_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st2_vld_q <= 1'b0;
    end else if (pipe_en) begin
      st2_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st2_sfree_q <= sfree_d;
      st2_kce_q   <= sq_kce;
      st2_km_q    <= sq_km;
    end
  end

  logic             md_vld;
  logic [NUM_W-1:0] md_p;
  logic [SD_W-1:0]  md_side;

  mmp_mul #(.AW(KCE_W), .BW(SF_W), .OW(NUM_W), .SW(SD_W)) u_mul_num (
    .clk_i, .rst_ni, .en_i(pipe_en), .vld_i(st2_vld_q),
    .a_i(st2_kce_q), .b_i(st2_sfree_q), .c_i('0),
    .side_i({st2_sfree_q, st2_km_q}),
    .vld_o(md_vld), .p_o(md_p), .side_o(md_side)
  );

  // Denominator, then zero and overflow checks ahead of the divider.
  logic             st3_vld_q, st4_vld_q;
  logic [NUM_W-1:0] st3_num_q, st4_num_q;
  logic [DEN_W-1:0] st3_den_q, st4_den_q;
  logic [SF_W-1:0]  st3_sfree_q, st4_sfree_q;
  logic             st4_zero_q, st4_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st3_vld_q <= 1'b0;
      st4_vld_q <= 1'b0;
    end else if (pipe_en) begin
      st3_vld_q <= md_vld;
      st4_vld_q <= st3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      st3_num_q   <= md_p;
      st3_den_q   <= DEN_W'(md_side[KM_W-1:0]) + DEN_W'(md_side[SD_W-1:KM_W]);
      st3_sfree_q <= md_side[SD_W-1:KM_W];
      st4_num_q   <= st3_num_q;
      st4_den_q   <= st3_den_q;
      st4_sfree_q <= st3_sfree_q;
      st4_zero_q  <= st3_den_q == '0;
      st4_ovf_q   <= DEN_W'(st3_num_q[NUM_W-1 -: HI_W]) >= st3_den_q;
    end
  end

  logic              div_vld;
  logic [PROP_W-1:0] div_q;
  logic [SQ_W-1:0]   div_side;
  logic              div_zero, div_ovf;
  logic [SF_W-1:0]   div_sfree;

  mmp_div #(.NW(NUM_W), .DNW(DEN_W), .QW(PROP_W), .SW(SQ_W)) u_div (
    .clk_i, .rst_ni, .en_i(pipe_en), .vld_i(st4_vld_q),
    .num_i(st4_num_q), .den_i(st4_den_q),
    .side_i({st4_sfree_q, st4_zero_q, st4_ovf_q}),
    .vld_o(div_vld), .quo_o(div_q), .side_o(div_side)
  );

  assign {div_sfree, div_zero, div_ovf} = div_side;

  logic              out_vld_q;
  logic [SF_W-1:0]   sfree_q;
  logic [PROP_W-1:0] prop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pipe_en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      sfree_q <= div_sfree;
      prop_q  <= div_zero ? '0 : (div_ovf ? {PROP_W{1'b1}} : div_q);
    end
  end

  assign out_valid_o      = out_vld_q;
  assign free_substrate_o = sfree_q;
  assign propensity_o     = prop_q;

  a_frozen_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(div_vld) && $stable(div_q))
    else $error("Divider output moved while the pipeline was stalled.");

  a_zero_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && div_vld && div_zero |=> out_valid_o && propensity_o == '0)
    else $error("Zero denominator did not give a zero propensity.");

  a_sat_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_en && div_vld && div_ovf && !div_zero |=> out_valid_o && (&propensity_o))
    else $error("Quotient overflow did not saturate the propensity.");

endmodule

[verif/tb_michaelis_menten_propensity_core.sv]
// Testbench for the Michaelis-Menten propensity core, checked item by item against a predictor.
module tb_michaelis_menten_propensity_core
  import mmp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW = 20;
  localparam int unsigned FB = 16;
  localparam int unsigned SFW = CW + FB;
  localparam int unsigned PW = 2 * CW + FB;
  localparam int unsigned LATENCY = 108;
  localparam int unsigned RAND_ITEMS = 1800;
  localparam longint unsigned CYCLE_LIMIT = 2000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [CW-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic [SFW-1:0] sfree;
    logic [PW-1:0]  prop;
  } rate_t;

  typedef struct {
    logic [31:0]   km;
    logic [31:0]   kcat;
    logic [CW-1:0] s;
    logic [CW-1:0] e;
    bit            known;
    rate_t         res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [CW-1:0] substrate = '0;
  logic [CW-1:0] enzyme = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SFW-1:0] free_substrate;
  logic [PW-1:0] propensity;

  rate_t rate_queue[$];
  logic [31:0] km_q16 = ONE_Q16;
  logic [31:0] kcat_q16 = ONE_Q16;
  int errors = 0;
  longint unsigned cycles = 0;
  bit hold_request = 1'b0;
  int gap_max = 4;

  michaelis_menten_propensity_core dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid),
    .in_stall_o(in_stall),
    .substrate_count_i(substrate),
    .enzyme_count_i(enzyme),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .free_substrate_o(free_substrate),
    .propensity_o(propensity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("michaelis_menten_propensity_core test failed");
      $finish;
    end
  end

  function automatic rate_t mm_rate(input logic [CW-1:0] s, input logic [CW-1:0] e,
                                    input logic [31:0] km, input logic [31:0] kc);
    logic [127:0] sfix, sub, mag, rad, root, t, sum, sf, den, q;
    bit neg;
    rate_t r;
    sfix = 128'(s) << FB;
    sub = 128'(km) + (128'(e) << FB);
    neg = sfix < sub;
    mag = neg ? sub - sfix : sfix - sub;
    rad = mag * mag + ((128'(km) << 2) * sfix);
    root = '0;
    for (int b = 39; b >= 0; b--) begin
      t = root | (128'(1) << b);
      if (t * t <= rad) root = t;
    end
    sum = neg ? root - mag : root + mag;
    sf = sum >> 1;
    if (sf > {SFW{1'b1}}) sf = {SFW{1'b1}};
    den = 128'(km) + sf;
    if (den == 0) begin
      q = '0;
    end else begin
      q = (128'(kc) * 128'(e) * sf) / den;
    end
    if (q > {PW{1'b1}}) q = {PW{1'b1}};
    r.sfree = sf[SFW-1:0];
    r.prop = q[PW-1:0];
    return r;
  endfunction

  // Result side: check every accepted item, stall on a rotating pattern.
  int hold_left = 0;
  initial begin
    rate_t exp_r;
    int stall_pct;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (rate_queue.size() == 0) begin
          $display("%0t: unexpected result sfree=%0h prop=%0h", $time, free_substrate,
                   propensity);
          errors++;
        end else begin
          exp_r = rate_queue.pop_front();
          if (free_substrate !== exp_r.sfree) begin
            $display("%0t: free_substrate expected %0h actual %0h", $time, exp_r.sfree,
                     free_substrate);
            errors++;
          end
          if (propensity !== exp_r.prop) begin
            $display("%0t: propensity expected %0h actual %0h", $time, exp_r.prop,
                     propensity);
            errors++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 400;
      end
      case ((cycles / 300) % 4)
        0: stall_pct = 0;
        1: stall_pct = 20;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic drain();
    while (rate_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 12) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_rates(input logic [31:0] km, input logic [31:0] kc);
    cfg_put(CFG_KM, km);
    cfg_put(CFG_UNMAPPED, $urandom());
    cfg_put(CFG_KCAT, kc);
    cfg_valid <= 1'b0;
    km_q16 = km;
    kcat_q16 = kc;
  endtask

  // Leaves in_valid high so a following item goes out in the same step.
  task automatic send_item(input logic [CW-1:0] s, input logic [CW-1:0] e, input bit known,
                           input rate_t res);
    in_valid <= 1'b1;
    substrate <= s;
    enzyme <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rate_queue.push_back(known ? res : mm_rate(s, e, km_q16, kcat_q16));
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  row_t rows[$];
  initial begin
    logic [CW-1:0] s, e;
    logic [31:0] km, kc;
    int burst;
    rate_t fill;
    rows = '{
      '{ONE_Q16, ONE_Q16, '0, '0, 1, '{36'd0, 56'd0}},
      '{ONE_Q16, ONE_Q16, '0, CNT_MAX, 1, '{36'd0, 56'd0}},
      '{ONE_Q16, ONE_Q16, CNT_MAX, '0, 0, '{'0, '0}},
      '{ONE_Q16, ONE_Q16, CNT_MAX, CNT_MAX, 0, '{'0, '0}},
      '{ONE_Q16, ONE_Q16, 20'd1, 20'd1, 0, '{'0, '0}},
      '{ONE_Q16, ONE_Q16, 20'hAAAAA, 20'h55555, 0, '{'0, '0}},
      '{32'd0, ONE_Q16, '0, '0, 1, '{36'd0, 56'd0}},
      '{32'd0, ONE_Q16, 20'd5, '0, 1, '{36'd327680, 56'd0}},
      '{32'd0, ONE_Q16, 20'd3, 20'd2, 1, '{36'd65536, 56'd131072}},
      '{32'd0, ONE_Q16, 20'd1, CNT_MAX, 0, '{'0, '0}},
      '{32'd0, ONE_Q16, CNT_MAX, 20'd1, 0, '{'0, '0}},
      '{ALL_ONES, ALL_ONES, CNT_MAX, CNT_MAX, 0, '{'0, '0}},
      '{ALL_ONES, ALL_ONES, '0, CNT_MAX, 0, '{'0, '0}},
      '{ALL_ONES, ALL_ONES, CNT_MAX, 20'd1, 0, '{'0, '0}},
      '{ALL_ONES, ALL_ONES, 20'h55555, 20'hAAAAA, 0, '{'0, '0}},
      '{ALL_ONES, 32'd0, CNT_MAX, CNT_MAX, 1, '{'0, 56'd0}},
      '{32'h0000_8000, ALL_ONES, 20'd7, 20'd3, 0, '{'0, '0}},
      '{32'h0000_8000, ALL_ONES, 20'd2, 20'd9, 0, '{'0, '0}}
    };
    // The row with kcat zero has an unknown free substrate; fill it from the predictor.
    fill = mm_rate(CNT_MAX, CNT_MAX, ALL_ONES, 32'd0);
    rows[15].res.sfree = fill.sfree;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].km != km_q16 || rows[i].kcat != kcat_q16) begin
        idle(1);
        drain();
        set_rates(rows[i].km, rows[i].kcat);
      end
      send_item(rows[i].s, rows[i].e, rows[i].known, rows[i].res);
    end
    idle(1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin km = ONE_Q16; kc = ONE_Q16; end
        1: begin km = 32'd0; kc = ALL_ONES; end
        2: begin km = ALL_ONES; kc = $urandom(); end
        3: begin km = $urandom_range(32'h0010_0000); kc = $urandom(); end
        4: begin km = $urandom(); kc = 32'd0; end
        default: begin km = $urandom(); kc = $urandom(); end
      endcase
      set_rates(km, kc);
      gap_max = (ph % 2) ? 0 : 6;
      burst = 0;
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        if (ph == 1 && n == 50) hold_request = 1'b1;
        if (ph == 3 && n == 150) begin
          idle(1);
          while (rate_queue.size() != 0) @(posedge clk);
        end
        if (burst == 0) begin
          burst = $urandom_range(1, 40);
          idle($urandom_range(gap_max));
        end
        burst--;
        case ($urandom_range(3))
          0: begin s = $urandom(); e = $urandom(); end
          1: begin s = $urandom_range(255); e = $urandom_range(255); end
          2: begin s = $urandom_range(1) ? CNT_MAX : '0; e = $urandom(); end
          default: begin s = $urandom(); e = $urandom_range(15); end
        endcase
        send_item(s, e, 1'b0, '{'0, '0});
      end
      idle(1);
      drain();
    end

    if (errors == 0) begin
      $display("michaelis_menten_propensity_core test passed");
    end else begin
      $display("michaelis_menten_propensity_core test failed");
    end
    $finish;
  end

endmodule
